// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ULTI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ULTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/ulti_pkg.sv
package ulti_pkg;

    localparam int MAT_DIM_DEF = 16;

    localparam logic [31:0] FP_ONE    = 32'h3F80_0000;
    localparam logic [31:0] FP_QNAN   = 32'hFFC0_0000;
    localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
    localparam logic [31:0] QUIET_BIT = 32'h0040_0000;

    // Count of leading zeros in a 27-bit word; 27 when the word is zero.
    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] cnt;
        cnt = 5'd27;
        for (int i = 0; i < 27; i++)
        begin
            if (v[i])
            begin
                cnt = 5'(26 - i);
            end
        end
        return cnt;
    endfunction

endpackage

// File: rtl/ulti_ram.sv
module ulti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/ulti_fmul.sv
// fp32 multiply, round to nearest even, three register stages.
module ulti_fmul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        out_valid,
    output logic [31:0] res
);

    logic        v1_reg, v2_reg, v3_reg;
    logic        sign1_reg, spec1_reg, sign2_reg, spec2_reg;
    logic [31:0] specv1_reg, specv2_reg, res_reg;
    logic [23:0] ma1_reg, mb1_reg;
    logic signed [10:0] e1_reg, e2_reg;
    logic [47:0] p2_reg;

    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0] ma, mb;
    logic [4:0]  lza, lzb;
    logic signed [10:0] expa, expb;
    logic [31:0] specv;
    logic        sgn;

    always_comb
    begin
        ea = a[30:23];
        eb = b[30:23];
        fa = a[22:0];
        fb = b[22:0];
        a_nan  = (ea == 8'hFF) && (fa != '0);
        b_nan  = (eb == 8'hFF) && (fb != '0);
        a_inf  = (ea == 8'hFF) && (fa == '0);
        b_inf  = (eb == 8'hFF) && (fb == '0);
        a_zero = (ea == 8'h00) && (fa == '0);
        b_zero = (eb == 8'h00) && (fb == '0);
        sgn = a[31] ^ b[31];
        ma = {ea != 8'h00, fa};
        mb = {eb != 8'h00, fb};
        lza = ulti_pkg::lzc27({ma, 3'b000});
        lzb = ulti_pkg::lzc27({mb, 3'b000});
        expa = $signed({3'b000, (ea == 8'h00) ? 8'd1 : ea}) - $signed({6'b0, lza});
        expb = $signed({3'b000, (eb == 8'h00) ? 8'd1 : eb}) - $signed({6'b0, lzb});
        if (a_nan)
        begin
            specv = a | ulti_pkg::QUIET_BIT;
        end
        else if (b_nan)
        begin
            specv = b | ulti_pkg::QUIET_BIT;
        end
        else if ((a_inf && b_zero) || (b_inf && a_zero))
        begin
            specv = ulti_pkg::FP_QNAN;
        end
        else if (a_inf || b_inf)
        begin
            specv = {sgn, 8'hFF, 23'd0};
        end
        else
        begin
            specv = {sgn, 31'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        sign1_reg  <= sgn;
        spec1_reg  <= a_nan | b_nan | a_inf | b_inf | a_zero | b_zero;
        specv1_reg <= specv;
        ma1_reg    <= ma << lza;
        mb1_reg    <= mb << lzb;
        e1_reg     <= expa + expb - 11'sd127;
        sign2_reg  <= sign1_reg;
        spec2_reg  <= spec1_reg;
        specv2_reg <= specv1_reg;
        e2_reg     <= e1_reg;
        p2_reg     <= ma1_reg * mb1_reg;
    end

    logic signed [10:0] e_n, sh;
    logic [47:0] m_n, shifted, mask;
    logic [5:0]  shc;
    logic [7:0]  expf;
    logic [22:0] frac;
    logic        g, st, up;
    logic [31:0] res_next;

    always_comb
    begin
        e_n = p2_reg[47] ? e2_reg + 11'sd1 : e2_reg;
        m_n = p2_reg[47] ? p2_reg : {p2_reg[46:0], 1'b0};
        sh  = 11'sd1 - e_n;
        shc = (sh > 11'sd48) ? 6'd48 : 6'(sh);
        mask = (48'd1 << shc) - 48'd1;
        shifted = m_n >> shc;
        if (e_n < 11'sd1)
        begin
            expf = 8'd0;
            frac = shifted[46:24];
            g    = shifted[23];
            st   = (|shifted[22:0]) | (|(m_n & mask));
        end
        else
        begin
            expf = e_n[7:0];
            frac = m_n[46:24];
            g    = m_n[23];
            st   = |m_n[22:0];
        end
        up = g & (st | frac[0]);
        if (spec2_reg)
        begin
            res_next = specv2_reg;
        end
        else if (e_n > 11'sd254)
        begin
            res_next = {sign2_reg, 8'hFF, 23'd0};
        end
        else
        begin
            res_next = {sign2_reg, {expf, frac} + {30'd0, up}};
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign res       = res_reg;

endmodule

// File: rtl/ulti_fsub.sv
// fp32 subtract a - b, round to nearest even, three register stages.
module ulti_fsub (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        out_valid,
    output logic [31:0] res
);

    logic        v1_reg, v2_reg, v3_reg;
    logic        spec1_reg, sign1_reg, zsign1_reg, sub1_reg;
    logic        spec2_reg, sign2_reg, zsign2_reg;
    logic [31:0] specv1_reg, specv2_reg, res_reg;
    logic [7:0]  ex1_reg, ex2_reg;
    logic [26:0] mx1_reg, my1_reg;
    logic [27:0] sum2_reg;

    logic [7:0]  ea, eb, ex, ey, d;
    logic [22:0] fa, fb;
    logic        sa, sb, a_nan, b_nan, a_inf, b_inf, swap, sx;
    logic [23:0] mx, my;
    logic [26:0] my27, my_al, al_mask;
    logic [31:0] specv;

    always_comb
    begin
        ea = a[30:23];
        eb = b[30:23];
        fa = a[22:0];
        fb = b[22:0];
        sa = a[31];
        sb = ~b[31];
        a_nan = (ea == 8'hFF) && (fa != '0);
        b_nan = (eb == 8'hFF) && (fb != '0);
        a_inf = (ea == 8'hFF) && (fa == '0);
        b_inf = (eb == 8'hFF) && (fb == '0);
        if (a_nan)
        begin
            specv = a | ulti_pkg::QUIET_BIT;
        end
        else if (b_nan)
        begin
            specv = b | ulti_pkg::QUIET_BIT;
        end
        else if (a_inf && b_inf && (sa != sb))
        begin
            specv = ulti_pkg::FP_QNAN;
        end
        else if (a_inf)
        begin
            specv = a;
        end
        else
        begin
            specv = {sb, b[30:0]};
        end
        swap = b[30:0] > a[30:0];
        sx = swap ? sb : sa;
        ex = swap ? ((eb == 8'h00) ? 8'd1 : eb) : ((ea == 8'h00) ? 8'd1 : ea);
        ey = swap ? ((ea == 8'h00) ? 8'd1 : ea) : ((eb == 8'h00) ? 8'd1 : eb);
        mx = swap ? {eb != 8'h00, fb} : {ea != 8'h00, fa};
        my = swap ? {ea != 8'h00, fa} : {eb != 8'h00, fb};
        d  = ex - ey;
        my27 = {my, 3'b000};
        al_mask = (27'd1 << d[4:0]) - 27'd1;
        if (d >= 8'd27)
        begin
            my_al = {26'd0, |my};
        end
        else
        begin
            my_al = (my27 >> d[4:0]) | {26'd0, |(my27 & al_mask)};
        end
    end

    always_ff @(posedge clk)
    begin
        spec1_reg  <= a_nan | b_nan | a_inf | b_inf;
        specv1_reg <= specv;
        sign1_reg  <= sx;
        zsign1_reg <= sa & sb;
        sub1_reg   <= sa ^ sb;
        ex1_reg    <= ex;
        mx1_reg    <= {mx, 3'b000};
        my1_reg    <= my_al;
        spec2_reg  <= spec1_reg;
        specv2_reg <= specv1_reg;
        sign2_reg  <= sign1_reg;
        zsign2_reg <= zsign1_reg;
        ex2_reg    <= ex1_reg;
        sum2_reg   <= sub1_reg ? {1'b0, mx1_reg} - {1'b0, my1_reg}
                               : {1'b0, mx1_reg} + {1'b0, my1_reg};
    end

    logic [4:0]  lz;
    logic [7:0]  lim, sh;
    logic [26:0] n;
    logic [8:0]  e_n;
    logic [7:0]  expf;
    logic        up;
    logic [31:0] res_next;

    always_comb
    begin
        lz  = ulti_pkg::lzc27(sum2_reg[26:0]);
        lim = ex2_reg - 8'd1;
        sh  = ({3'b000, lz} < lim) ? {3'b000, lz} : lim;
        if (sum2_reg[27])
        begin
            n   = {sum2_reg[27:2], sum2_reg[1] | sum2_reg[0]};
            e_n = {1'b0, ex2_reg} + 9'd1;
        end
        else
        begin
            n   = sum2_reg[26:0] << sh;
            e_n = {1'b0, ex2_reg} - {1'b0, sh};
        end
        expf = n[26] ? e_n[7:0] : 8'd0;
        up = n[2] & ((|n[1:0]) | n[3]);
        if (spec2_reg)
        begin
            res_next = specv2_reg;
        end
        else if (sum2_reg == '0)
        begin
            res_next = {zsign2_reg, 31'd0};
        end
        else if (e_n >= 9'd255)
        begin
            res_next = {sign2_reg, 8'hFF, 23'd0};
        end
        else
        begin
            res_next = {sign2_reg, {expf, n[25:3]} + {30'd0, up}};
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign res       = res_reg;

endmodule

// File: rtl/unit_lower_tri_inverse.sv
// Streaming inverse of a unit lower triangular fp32 matrix. Elements come in row-major
// order, one beat per accepted start (start high while busy is low). Diagonal and upper
// entries are stored but ignored. The beat that completes row j makes busy rise on the
// next cycle; the block then solves row j of the inverse on one shared fp32 multiplier
// and one shared fp32 subtractor, both three-stage pipelines used one operation at a
// time, because each multiply-subtract depends on the accumulator left by the one before.
// Each multiply-subtract takes a matrix and a work memory read, a multiply and a
// subtract, and each new column of the row first seeds its accumulator with zero minus
// the matrix entry. Busy stays high through the solve and the emit state of the row;
// row 1 needs no multiply-subtract and row 0 no solve. Beats that do not end a row
// leave busy low. After the solve the row leaves as MAT_DIM result beats on consecutive
// cycles, columns 0 to MAT_DIM-1, each shown for exactly one cycle with strobe high.
// The receiver cannot stall these beats, and they keep coming after busy has fallen:
// the last beats of a row show with busy low, delayed by em_valid_reg and strobe_reg.
// row_done marks the last beat of a row, matrix_done the last beat of the matrix; the
// element counter then wraps and the next matrix begins. out_row and out_col carry the
// low four bits of the indexes. NaN, infinity and subnormal values follow IEEE rules,
// with round to nearest even and no fused operations. No clearing pass is needed.
module unit_lower_tri_inverse #(
    parameter int MAT_DIM = ulti_pkg::MAT_DIM_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] element_bits,
    output logic        strobe,
    output logic [31:0] inv_bits,
    output logic [3:0]  out_row,
    output logic [3:0]  out_col,
    output logic        row_done,
    output logic        matrix_done
);

    localparam int W     = $clog2(MAT_DIM);
    localparam int DEPTH = MAT_DIM * MAT_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [W-1:0] LAST = W'(MAT_DIM - 1);

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_DIAG_RD   = 10'b00_0000_0010,
        ST_DIAG_WR   = 10'b00_0000_0100,
        ST_ACC_RD    = 10'b00_0000_1000,
        ST_ACC_GO    = 10'b00_0001_0000,
        ST_ACC_WAIT  = 10'b00_0010_0000,
        ST_PROD_RD   = 10'b00_0100_0000,
        ST_PROD_GO   = 10'b00_1000_0000,
        ST_PROD_WAIT = 10'b01_0000_0000,
        ST_EMIT      = 10'b10_0000_0000
    } state_t;

    state_t      state_reg, state_next;
    logic [W-1:0] row_reg, row_next, col_reg, col_next;
    logic [W-1:0] j_reg, j_next, k_reg, k_next, m_reg, m_next, c_reg, c_next;
    logic [31:0]  acc_reg, acc_next;
    logic         em_valid_reg;
    logic [W-1:0] em_col_reg;
    logic         strobe_reg, row_done_reg, matrix_done_reg;
    logic [31:0]  inv_bits_reg;
    logic [3:0]   out_row_reg, out_col_reg;

    logic         accept;
    logic [W-1:0] rd_row, rd_col;
    logic [AW-1:0] mat_waddr, mat_raddr;
    logic [31:0]  mat_rdata, work_rdata;
    logic         work_we;
    logic [W-1:0] work_waddr, work_raddr;
    logic [31:0]  work_wdata;
    logic         mul_out_valid, sub_in_valid, sub_out_valid;
    logic [31:0]  mul_res, sub_a, sub_b, sub_res;
    logic         last_prod;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // Matrix store: written by element beats, read by the solver.
    assign mat_waddr = AW'(row_reg * MAT_DIM + col_reg);
    assign mat_raddr = AW'(rd_row * MAT_DIM + rd_col);

    always_comb
    begin
        case (state_reg)
            ST_DIAG_RD:
            begin
                rd_row = j_reg;
                rd_col = j_reg - W'(1);
            end
            ST_PROD_RD:
            begin
                rd_row = m_reg;
                rd_col = k_reg;
            end
            default:
            begin
                rd_row = j_reg;
                rd_col = k_reg;
            end
        endcase
    end

    ulti_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_mat_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (mat_waddr),
        .wdata (element_bits),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    // Work vector holds the solved entries of the current row of the inverse.
    assign last_prod  = ({1'b0, m_reg} == ({1'b0, k_reg} + (W+1)'(1)));
    assign work_we    = (state_reg == ST_DIAG_WR) ||
                        ((state_reg == ST_PROD_WAIT) && sub_out_valid && last_prod);
    assign work_waddr = (state_reg == ST_DIAG_WR) ? j_reg - W'(1) : k_reg;
    assign work_wdata = (state_reg == ST_DIAG_WR) ? mat_rdata ^ ulti_pkg::SIGN_MASK : sub_res;
    assign work_raddr = (state_reg == ST_EMIT) ? c_reg : m_reg;

    ulti_ram #(.WIDTH(32), .DEPTH(MAT_DIM)) u_work_ram (
        .clk   (clk),
        .we    (work_we),
        .waddr (work_waddr),
        .wdata (work_wdata),
        .raddr (work_raddr),
        .rdata (work_rdata)
    );

    ulti_fmul u_fmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (state_reg == ST_PROD_GO),
        .a         (work_rdata),
        .b         (mat_rdata),
        .out_valid (mul_out_valid),
        .res       (mul_res)
    );

    // The subtractor starts a column from zero, then takes each rounded product.
    assign sub_in_valid = (state_reg == ST_ACC_GO) || mul_out_valid;
    assign sub_a        = (state_reg == ST_ACC_GO) ? 32'd0 : acc_reg;
    assign sub_b        = (state_reg == ST_ACC_GO) ? mat_rdata : mul_res;

    ulti_fsub u_fsub (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sub_in_valid),
        .a         (sub_a),
        .b         (sub_b),
        .out_valid (sub_out_valid),
        .res       (sub_res)
    );

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        m_next     = m_reg;
        c_next     = c_reg;
        acc_next   = acc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (col_reg == LAST)
                    begin
                        col_next = '0;
                        row_next = (row_reg == LAST) ? '0 : row_reg + W'(1);
                        j_next   = row_reg;
                        c_next   = '0;
                        state_next = (row_reg == '0) ? ST_EMIT : ST_DIAG_RD;
                    end
                    else
                    begin
                        col_next = col_reg + W'(1);
                    end
                end
            end
            ST_DIAG_RD:
            begin
                state_next = ST_DIAG_WR;
            end
            ST_DIAG_WR:
            begin
                c_next = '0;
                k_next = j_reg - W'(2);
                state_next = (j_reg == W'(1)) ? ST_EMIT : ST_ACC_RD;
            end
            ST_ACC_RD:
            begin
                state_next = ST_ACC_GO;
            end
            ST_ACC_GO:
            begin
                state_next = ST_ACC_WAIT;
            end
            ST_ACC_WAIT:
            begin
                if (sub_out_valid)
                begin
                    acc_next   = sub_res;
                    m_next     = j_reg - W'(1);
                    state_next = ST_PROD_RD;
                end
            end
            ST_PROD_RD:
            begin
                state_next = ST_PROD_GO;
            end
            ST_PROD_GO:
            begin
                state_next = ST_PROD_WAIT;
            end
            ST_PROD_WAIT:
            begin
                if (sub_out_valid)
                begin
                    acc_next = sub_res;
                    if (last_prod)
                    begin
                        c_next = '0;
                        k_next = k_reg - W'(1);
                        state_next = (k_reg == '0) ? ST_EMIT : ST_ACC_RD;
                    end
                    else
                    begin
                        m_next     = m_reg - W'(1);
                        state_next = ST_PROD_RD;
                    end
                end
            end
            ST_EMIT:
            begin
                c_next = c_reg + W'(1);
                if (c_reg == LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            row_reg         <= '0;
            col_reg         <= '0;
            em_valid_reg    <= 1'b0;
            strobe_reg      <= 1'b0;
            row_done_reg    <= 1'b0;
            matrix_done_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            em_valid_reg    <= (state_reg == ST_EMIT);
            strobe_reg      <= em_valid_reg;
            row_done_reg    <= em_valid_reg && (em_col_reg == LAST);
            matrix_done_reg <= em_valid_reg && (em_col_reg == LAST) && (j_reg == LAST);
        end
    end

    // Payload registers: entries below the diagonal come from the work vector.
    always_ff @(posedge clk)
    begin
        j_reg      <= j_next;
        k_reg      <= k_next;
        m_reg      <= m_next;
        c_reg      <= c_next;
        acc_reg    <= acc_next;
        em_col_reg <= c_reg;
        if (em_col_reg < j_reg)
        begin
            inv_bits_reg <= work_rdata;
        end
        else if (em_col_reg == j_reg)
        begin
            inv_bits_reg <= ulti_pkg::FP_ONE;
        end
        else
        begin
            inv_bits_reg <= 32'd0;
        end
        out_row_reg <= 4'(j_reg);
        out_col_reg <= 4'(em_col_reg);
    end

    assign strobe      = strobe_reg;
    assign inv_bits    = inv_bits_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign row_done    = row_done_reg;
    assign matrix_done = matrix_done_reg;

endmodule

// File: rtl/ulti_checker.sv
`include "assert_macros.svh"

module ulti_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       strobe,
    input logic [3:0] out_col,
    input logic       row_done,
    input logic       matrix_done
);

    // Completion flags only appear on a result beat.
    `ULTI_ASSERT_SAME(a_flags_on_beat, clk, rst_n, (row_done || matrix_done), strobe)
    `ULTI_ASSERT_SAME(a_matrix_ends_row, clk, rst_n, matrix_done, row_done)
    // A row leaves as one unbroken burst with rising columns, then a gap.
    `ULTI_ASSERT_NEXT(a_burst_holds, clk, rst_n, (strobe && !row_done), strobe)
    `ULTI_ASSERT_NEXT(a_col_steps, clk, rst_n, (strobe && !row_done), (out_col == 4'($past(out_col) + 4'd1)))
    `ULTI_ASSERT_NEXT(a_gap_after_row, clk, rst_n, (strobe && row_done), !strobe)

endmodule

bind unit_lower_tri_inverse ulti_checker u_ulti_checker (.*);
